[sv/nmea_sentence_framer_assert.svh]
// Assertion macros used by the sentence engine RTL.
`ifndef NMEA_SENTENCE_FRAMER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define NSF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define NSF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/nsf_pkg.sv]
// Types, character codes and helpers for the NMEA sentence framer.
`default_nettype none

package nsf_pkg;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_START,
        CLS_END
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [7:0]  ch;
    } nsf_item_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // Only the first characters of a term are ever inspected.
    localparam int NAME_LEN = 6;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GGA   = 2'd2;

    localparam logic [7:0] MASK_RMC_BASE = 8'h03;
    localparam logic [7:0] MASK_RMC_FIX  = 8'h1C;
    localparam logic [7:0] MASK_GGA_BASE = 8'hC2;
    localparam logic [7:0] MASK_GGA_FIX  = 8'h24;

    function automatic logic [7:0] hex_value(input logic [7:0] a);
        logic [7:0] v;
        if (a >= CH_UP_A && a <= CH_UP_F) begin
            v = a - CH_UP_A + 8'd10;
        end else if (a >= CH_LO_A && a <= CH_LO_F) begin
            v = a - CH_LO_A + 8'd10;
        end else begin
            v = a - CH_ZERO;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/nmea_sentence_framer.sv]
// Top level of the NMEA sentence framer: classifier, queue and sentence engine.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_rx_char (one character per beat)
//   m_        out        m_valid/m_ready    status, kind, flags, mask, term char, counters
//
// One result beat per input beat; sustained rate is one character per cycle while m_ready stays high.
// From input beat to result beat the path is registered in the classifier register,
// the queue, and the engine's result register.
// The engine updates all sentence state for a character in a single update; the
// term-end match, checksum compare and counter increments sit in that update.
// Reset (aresetn low, synchronous) clears sentence state (not the stored term characters), counters and valids.
// A stall on m_ready holds the result register; the queue and classifier absorb
// further beats before s_ready drops.
`default_nettype none

module nmea_sentence_framer
    import nsf_pkg::*;
#(
    parameter int MAX_TERM_CHARS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_char,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_sentence_kind,
    output logic             m_has_fix,
    output logic [7:0]       m_commit_mask,
    output logic             m_south,
    output logic             m_west,
    output logic [7:0]       m_term_index,
    output logic [7:0]       m_term_char,
    output logic             m_char_valid,
    output logic [31:0]      m_passed_count,
    output logic [31:0]      m_failed_count,
    output logic [31:0]      m_fix_count
);

    // Classified beat from the front into the queue
    logic      f_valid;
    logic      f_ready;
    nsf_item_t f_item;

    // Queue head into the engine
    logic      q_valid;
    logic      q_ready;
    nsf_item_t q_item;

    // Classify: sort each character into data, sentence start or term end.
    nsf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_char (s_rx_char),
        .f_valid   (f_valid),
        .f_item    (f_item),
        .f_ready   (f_ready)
    );

    // Decouple: hold up to two classified beats so either side may stall alone.
    nsf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_item   (q_item),
        .pop_ready  (q_ready)
    );

    // Execute: advance term state, check parity, update flags and counters.
    nsf_engine #(
        .MAX_TERM_CHARS (MAX_TERM_CHARS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_ready         (q_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_sentence_kind (m_sentence_kind),
        .m_has_fix       (m_has_fix),
        .m_commit_mask   (m_commit_mask),
        .m_south         (m_south),
        .m_west          (m_west),
        .m_term_index    (m_term_index),
        .m_term_char     (m_term_char),
        .m_char_valid    (m_char_valid),
        .m_passed_count  (m_passed_count),
        .m_failed_count  (m_failed_count),
        .m_fix_count     (m_fix_count)
    );

endmodule

`default_nettype wire

[sv/nsf_front.sv]
// Input stage: registers and classifies each received character.
`default_nettype none

module nsf_front
    import nsf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_char,
    output logic            f_valid,
    output nsf_item_t       f_item,
    input  wire logic       f_ready
);

    logic        valid_reg;
    logic        valid_next;
    nsf_item_t   item_reg;
    nsf_item_t   item_next;
    char_class_t cls;

    always_comb begin
        priority if (s_rx_char == CH_COMMA || s_rx_char == CH_CR ||
                     s_rx_char == CH_LF || s_rx_char == CH_STAR) begin
            cls = CLS_END;
        end else if (s_rx_char == CH_DOLLAR) begin
            cls = CLS_START;
        end else begin
            cls = CLS_DATA;
        end
    end

    assign s_ready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg && !f_ready;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next   = 1'b1;
            item_next.cls = cls;
            item_next.ch  = s_rx_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

`default_nettype wire

[sv/nsf_queue.sv]
// Two-entry queue between the classifier and the sentence engine.
`default_nettype none

module nsf_queue
    import nsf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output logic           push_ready,
    input  nsf_item_t      push_item,
    output logic           pop_valid,
    output nsf_item_t      pop_item,
    input  wire logic      pop_ready
);

    nsf_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[sv/nsf_engine.sv]
// Sentence engine: term state, checksum, flags, counters and result register.
`default_nettype none
`include "nmea_sentence_framer_assert.svh"

module nsf_engine
    import nsf_pkg::*;
#(
    parameter int MAX_TERM_CHARS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  nsf_item_t        q_item,
    output logic             q_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [1:0]       m_sentence_kind,
    output logic             m_has_fix,
    output logic [7:0]       m_commit_mask,
    output logic             m_south,
    output logic             m_west,
    output logic [7:0]       m_term_index,
    output logic [7:0]       m_term_char,
    output logic             m_char_valid,
    output logic [31:0]      m_passed_count,
    output logic [31:0]      m_failed_count,
    output logic [31:0]      m_fix_count
);

    localparam int OFF_W = $clog2(MAX_TERM_CHARS);
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_TERM_CHARS - 1);

    // Sentence state
    logic [7:0]       parity_reg,  parity_next;
    logic [7:0]       store_reg [NAME_LEN];
    logic [7:0]       store_next [NAME_LEN];
    logic [OFF_W-1:0] offset_reg,  offset_next;
    logic [7:0]       term_num_reg, term_num_next;
    logic [1:0]       kind_reg,    kind_next;
    logic             cs_reg,      cs_next;
    logic             fix_reg,     fix_next;
    logic             south_reg,   south_next;
    logic             west_reg,    west_next;
    logic [31:0]      pass_reg,    pass_next;
    logic [31:0]      fail_reg,    fail_next;
    logic [31:0]      fixcnt_reg,  fixcnt_next;

    // Result register
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg,  status_next;
    logic [7:0]       mask_reg,    mask_next;
    logic [7:0]       tidx_reg,    tidx_next;
    logic [7:0]       tchar_reg,   tchar_next;
    logic             cvalid_reg,  cvalid_next;

    logic [7:0] term_ch [NAME_LEN];
    logic [7:0] hex_hi;
    logic [7:0] hex_lo;
    logic [7:0] csum;
    logic       is_rmc;
    logic       is_gga;
    logic       pop;
    logic       room;

    assign pop     = q_valid && (!m_valid_reg || m_ready);
    assign q_ready = pop;
    assign room    = (offset_reg < OFF_LIMIT);

    // Positions at or beyond the fill point read as zero.
    always_comb begin
        for (int i = 0; i < NAME_LEN; i++) begin
            term_ch[i] = (OFF_W'(i) < offset_reg) ? store_reg[i] : 8'h00;
        end
    end

    assign hex_hi = hex_value(term_ch[0]);
    assign hex_lo = hex_value(term_ch[1]);
    assign csum   = {hex_hi[3:0], 4'h0} + hex_lo;
    assign is_rmc = term_ch[0] == CH_G && (term_ch[1] == CH_P || term_ch[1] == CH_N) &&
                    term_ch[2] == CH_R && term_ch[3] == CH_M && term_ch[4] == CH_C &&
                    term_ch[5] == 8'h00;
    assign is_gga = term_ch[0] == CH_G && (term_ch[1] == CH_P || term_ch[1] == CH_N) &&
                    term_ch[2] == CH_G && term_ch[3] == CH_G && term_ch[4] == CH_UP_A &&
                    term_ch[5] == 8'h00;

    always_comb begin
        parity_next   = parity_reg;
        offset_next   = offset_reg;
        term_num_next = term_num_reg;
        kind_next     = kind_reg;
        cs_next       = cs_reg;
        fix_next      = fix_reg;
        south_next    = south_reg;
        west_next     = west_reg;
        pass_next     = pass_reg;
        fail_next     = fail_reg;
        fixcnt_next   = fixcnt_reg;
        status_next   = ST_NONE;
        mask_next     = 8'h00;
        tidx_next     = 8'h00;
        tchar_next    = 8'h00;
        cvalid_next   = 1'b0;
        for (int i = 0; i < NAME_LEN; i++) begin
            store_next[i] = store_reg[i];
        end

        if (pop) begin
            unique case (q_item.cls)
                CLS_END: begin
                    parity_next = parity_reg ^ ((q_item.ch == CH_COMMA) ? q_item.ch : 8'h00);
                    if (cs_reg) begin
                        if (csum != parity_next) begin
                            status_next = ST_FAIL;
                            fail_next   = fail_reg + 32'd1;
                        end else begin
                            status_next = ST_PASS;
                            pass_next   = pass_reg + 32'd1;
                            if (fix_reg) begin
                                fixcnt_next = fixcnt_reg + 32'd1;
                            end
                            unique case (kind_reg)
                                KIND_RMC: mask_next = MASK_RMC_BASE |
                                                      (fix_reg ? MASK_RMC_FIX : 8'h00);
                                KIND_GGA: mask_next = MASK_GGA_BASE |
                                                      (fix_reg ? MASK_GGA_FIX : 8'h00);
                                default:  mask_next = 8'h00;
                            endcase
                        end
                    end else if (term_num_reg == 8'd0) begin
                        kind_next = is_rmc ? KIND_RMC : (is_gga ? KIND_GGA : KIND_OTHER);
                    end else if (term_ch[0] != 8'h00) begin
                        unique case (kind_reg)
                            KIND_RMC: begin
                                if (term_num_reg == 8'd2) fix_next = (term_ch[0] == CH_UP_A);
                                if (term_num_reg == 8'd4) south_next = (term_ch[0] == CH_S);
                                if (term_num_reg == 8'd6) west_next = (term_ch[0] == CH_W);
                            end
                            KIND_GGA: begin
                                if (term_num_reg == 8'd3) south_next = (term_ch[0] == CH_S);
                                if (term_num_reg == 8'd5) west_next = (term_ch[0] == CH_W);
                                if (term_num_reg == 8'd6) fix_next = (term_ch[0] > CH_ZERO);
                            end
                            default: ;
                        endcase
                    end
                    if (term_num_reg != 8'hFF) begin
                        term_num_next = term_num_reg + 8'd1;
                    end
                    offset_next = '0;
                    cs_next     = (q_item.ch == CH_STAR);
                end
                CLS_START: begin
                    term_num_next = 8'd0;
                    offset_next   = '0;
                    parity_next   = 8'h00;
                    kind_next     = KIND_OTHER;
                    cs_next       = 1'b0;
                    fix_next      = 1'b0;
                end
                default: begin
                    if (room) begin
                        for (int i = 0; i < NAME_LEN; i++) begin
                            if (offset_reg == OFF_W'(i)) begin
                                store_next[i] = q_item.ch;
                            end
                        end
                        offset_next = offset_reg + OFF_W'(1);
                        cvalid_next = 1'b1;
                        tchar_next  = q_item.ch;
                        tidx_next   = term_num_reg;
                    end
                    if (!cs_reg) begin
                        parity_next = parity_reg ^ q_item.ch;
                    end
                end
            endcase
        end

        m_valid_next = pop || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg   <= 8'h00;
            offset_reg   <= '0;
            term_num_reg <= 8'd0;
            kind_reg     <= KIND_OTHER;
            cs_reg       <= 1'b0;
            fix_reg      <= 1'b0;
            south_reg    <= 1'b0;
            west_reg     <= 1'b0;
            pass_reg     <= 32'd0;
            fail_reg     <= 32'd0;
            fixcnt_reg   <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            parity_reg   <= parity_next;
            offset_reg   <= offset_next;
            term_num_reg <= term_num_next;
            kind_reg     <= kind_next;
            cs_reg       <= cs_next;
            fix_reg      <= fix_next;
            south_reg    <= south_next;
            west_reg     <= west_next;
            pass_reg     <= pass_next;
            fail_reg     <= fail_next;
            fixcnt_reg   <= fixcnt_next;
            m_valid_reg  <= m_valid_next;
        end
        for (int i = 0; i < NAME_LEN; i++) begin
            store_reg[i] <= store_next[i];
        end
        if (pop) begin
            status_reg <= status_next;
            mask_reg   <= mask_next;
            tidx_reg   <= tidx_next;
            tchar_reg  <= tchar_next;
            cvalid_reg <= cvalid_next;
        end
    end

    // Flags and counters are stored state, so the result shows their new values.
    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_sentence_kind = kind_reg;
    assign m_has_fix       = fix_reg;
    assign m_commit_mask   = mask_reg;
    assign m_south         = south_reg;
    assign m_west          = west_reg;
    assign m_term_index    = tidx_reg;
    assign m_term_char     = tchar_reg;
    assign m_char_valid    = cvalid_reg;
    assign m_passed_count  = pass_reg;
    assign m_failed_count  = fail_reg;
    assign m_fix_count     = fixcnt_reg;

    `NSF_ASSERT_IMP(a_data_no_status, aclk, aresetn, m_valid_reg && cvalid_reg, status_reg == ST_NONE, "data beat carries a checksum status")
    `NSF_ASSERT_IMP(a_mask_on_pass, aclk, aresetn, m_valid_reg && mask_reg != 8'h00, status_reg == ST_PASS, "commit mask without a pass")
    `NSF_ASSERT_NXT(a_start_clears, aclk, aresetn, pop && q_item.cls == CLS_START, parity_reg == 8'h00 && offset_reg == '0 && term_num_reg == 8'd0, "start did not clear term state")
    `NSF_ASSERT_NXT(a_pass_count_hold, aclk, aresetn, !(pop && status_next == ST_PASS), $stable(pass_reg), "pass counter moved without a pass")

endmodule

`default_nettype wire
